FILE: rtl/psdm_pkg.sv
`timescale 1ns / 1ps

package psdm_pkg;

    localparam int DIST_W      = 22;
    localparam int OUT_DIST_W  = 21;
    localparam int OUT_TDATA_W = 24;

    typedef logic [DIST_W-1:0]     dist_t;
    typedef logic [OUT_DIST_W-1:0] out_dist_t;

    localparam dist_t     DIST_MAX     = 22'h3F_FFFF;
    localparam out_dist_t OUT_DIST_MAX = 21'h1F_FFFF;
    localparam out_dist_t THRESH_RESET = 21'd50;

endpackage

FILE: rtl/point_segment_distance_min.sv
`timescale 1ns / 1ps

// channel  | dir | signals                      | contents
// ---------+-----+------------------------------+-----------------------------------------
// s_       | in  | tvalid tready tdata tuser    | one segment item, tlast = last_segment
// m_       | out | tvalid tready tdata tuser    | run minimum and near flag
// cfg_     | in  | wr_en wr_data                | near_threshold
//
// An item passes the bit-serial multiplier pass (ST_MUL) and ST_EVAL. When the
// projection is clamped to an end it then goes to ST_FOLD; else the radix-2
// modular divider (ST_DIV) and ST_SUB run before ST_FOLD.
// Reset clears the running minimum to all ones, the threshold to 50 and the output valid.
// The next item is taken while a result waits in the output register; an item that
// ends a run holds in its last cycle until that register is free.
module point_segment_distance_min #(
    parameter int COORD_BITS = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // point_x, point_y, start_x, start_y, end_x, end_y, zero fill
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // first_segment
    input  logic [0:0] s_tuser,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // min_sq_distance, zero fill
    output logic [psdm_pkg::OUT_TDATA_W-1:0] m_tdata,
    // near
    output logic [0:0] m_tuser,
    input  logic cfg_wr_en,
    input  logic [psdm_pkg::OUT_DIST_W-1:0] cfg_wr_data
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 3;
    localparam int LW = 2 * COORD_BITS + 1;
    localparam int SW = LW + 2;
    localparam int CW = $clog2(LW);
    localparam int XW = (LW > psdm_pkg::DIST_W) ? LW : psdm_pkg::DIST_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SUB  = 3'd4;
    localparam logic [2:0] ST_FOLD = 3'd5;

    function automatic logic signed [PW-1:0] term(input logic signed [PW-1:0] m,
                                                  input logic b, input logic neg);
        logic signed [PW-1:0] t;
        t = '0;
        if (b)
        begin
            t = neg ? -m : m;
        end
        return t;
    endfunction

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    psdm_pkg::dist_t run_min_reg, run_min_next;
    psdm_pkg::out_dist_t thresh_reg;
    logic m_tvalid_reg, m_tvalid_next;

    logic [DW-1:0] q_apx_reg, q_apy_reg, q_abx_reg, q_aby_reg, q_bpx_reg, q_bpy_reg;
    logic [DW-1:0] q_apx_next, q_apy_next, q_abx_next, q_aby_next, q_bpx_next, q_bpy_next;
    logic signed [PW-1:0] m_apx_reg, m_apy_reg, m_abx_reg, m_aby_reg, m_bpx_reg, m_bpy_reg;
    logic signed [PW-1:0] m_apx_next, m_apy_next, m_abx_next, m_aby_next;
    logic signed [PW-1:0] m_bpx_next, m_bpy_next;
    logic signed [PW-1:0] acc_ap2_reg, acc_bp2_reg, acc_dot_reg, acc_len2_reg;
    logic signed [PW-1:0] acc_ap2_next, acc_bp2_next, acc_dot_next, acc_len2_next;
    logic [LW-1:0] dsh_reg, dsh_next, rem_reg, rem_next, quo_reg, quo_next;
    logic [LW-1:0] dist_reg, dist_next;
    logic first_reg, first_next, last_reg, last_next;
    psdm_pkg::out_dist_t m_dist_reg, m_dist_next;
    logic m_near_reg, m_near_next;

    logic [COORD_BITS-1:0] px, py, ax, ay, bx, by;
    logic signed [DW-1:0] d_apx, d_apy, d_abx, d_aby, d_bpx, d_bpy;
    logic accept, out_free, neg;
    logic [SW-1:0] s_sum, len_e, len2_e;
    logic k1, k2;
    logic [XW-1:0] dist_ext;
    psdm_pkg::dist_t d_sat, min_new;

    assign px = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign py = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign ax = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign ay = s_tdata[3*COORD_BITS +: COORD_BITS];
    assign bx = s_tdata[4*COORD_BITS +: COORD_BITS];
    assign by = s_tdata[5*COORD_BITS +: COORD_BITS];

    assign d_apx = signed'({1'b0, px}) - signed'({1'b0, ax});
    assign d_apy = signed'({1'b0, py}) - signed'({1'b0, ay});
    assign d_abx = signed'({1'b0, bx}) - signed'({1'b0, ax});
    assign d_aby = signed'({1'b0, by}) - signed'({1'b0, ay});
    assign d_bpx = signed'({1'b0, px}) - signed'({1'b0, bx});
    assign d_bpy = signed'({1'b0, py}) - signed'({1'b0, by});

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign neg      = (cnt_reg == '0);

    // modular divider step: rem stays below len2, quo = floor(dot * prefix / len2)
    assign s_sum  = {1'b0, rem_reg, 1'b0}
                  + (dsh_reg[LW-1] ? {2'b00, acc_dot_reg[LW-1:0]} : '0);
    assign len_e  = {2'b00, acc_len2_reg[LW-1:0]};
    assign len2_e = {1'b0, acc_len2_reg[LW-1:0], 1'b0};
    assign k2     = (s_sum >= len2_e);
    assign k1     = (s_sum >= len_e);

    assign dist_ext = XW'(dist_reg);
    assign d_sat    = (dist_ext > XW'(psdm_pkg::DIST_MAX)) ? psdm_pkg::DIST_MAX
                                                           : dist_ext[psdm_pkg::DIST_W-1:0];
    assign min_new  = (first_reg || d_sat < run_min_reg) ? d_sat : run_min_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        run_min_next  = run_min_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        q_apx_next    = q_apx_reg;
        q_apy_next    = q_apy_reg;
        q_abx_next    = q_abx_reg;
        q_aby_next    = q_aby_reg;
        q_bpx_next    = q_bpx_reg;
        q_bpy_next    = q_bpy_reg;
        m_apx_next    = m_apx_reg;
        m_apy_next    = m_apy_reg;
        m_abx_next    = m_abx_reg;
        m_aby_next    = m_aby_reg;
        m_bpx_next    = m_bpx_reg;
        m_bpy_next    = m_bpy_reg;
        acc_ap2_next  = acc_ap2_reg;
        acc_bp2_next  = acc_bp2_reg;
        acc_dot_next  = acc_dot_reg;
        acc_len2_next = acc_len2_reg;
        dsh_next      = dsh_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dist_next     = dist_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        m_dist_next   = m_dist_reg;
        m_near_next   = m_near_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    q_apx_next    = d_apx;
                    q_apy_next    = d_apy;
                    q_abx_next    = d_abx;
                    q_aby_next    = d_aby;
                    q_bpx_next    = d_bpx;
                    q_bpy_next    = d_bpy;
                    m_apx_next    = {{(PW-DW){d_apx[DW-1]}}, d_apx};
                    m_apy_next    = {{(PW-DW){d_apy[DW-1]}}, d_apy};
                    m_abx_next    = {{(PW-DW){d_abx[DW-1]}}, d_abx};
                    m_aby_next    = {{(PW-DW){d_aby[DW-1]}}, d_aby};
                    m_bpx_next    = {{(PW-DW){d_bpx[DW-1]}}, d_bpx};
                    m_bpy_next    = {{(PW-DW){d_bpy[DW-1]}}, d_bpy};
                    acc_ap2_next  = '0;
                    acc_bp2_next  = '0;
                    acc_dot_next  = '0;
                    acc_len2_next = '0;
                    first_next    = s_tuser[0];
                    last_next     = s_tlast;
                    cnt_next      = CW'(DW - 1);
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // LSB first; the sign bit on the last pass carries negative weight
                acc_ap2_next  = acc_ap2_reg + term(m_apx_reg, q_apx_reg[0], neg)
                                            + term(m_apy_reg, q_apy_reg[0], neg);
                acc_bp2_next  = acc_bp2_reg + term(m_bpx_reg, q_bpx_reg[0], neg)
                                            + term(m_bpy_reg, q_bpy_reg[0], neg);
                acc_dot_next  = acc_dot_reg + term(m_apx_reg, q_abx_reg[0], neg)
                                            + term(m_apy_reg, q_aby_reg[0], neg);
                acc_len2_next = acc_len2_reg + term(m_abx_reg, q_abx_reg[0], neg)
                                             + term(m_aby_reg, q_aby_reg[0], neg);
                q_apx_next = q_apx_reg >> 1;
                q_apy_next = q_apy_reg >> 1;
                q_abx_next = q_abx_reg >> 1;
                q_aby_next = q_aby_reg >> 1;
                q_bpx_next = q_bpx_reg >> 1;
                q_bpy_next = q_bpy_reg >> 1;
                m_apx_next = m_apx_reg <<< 1;
                m_apy_next = m_apy_reg <<< 1;
                m_abx_next = m_abx_reg <<< 1;
                m_aby_next = m_aby_reg <<< 1;
                m_bpx_next = m_bpx_reg <<< 1;
                m_bpy_next = m_bpy_reg <<< 1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EVAL:
            begin
                priority if (acc_len2_reg == '0 || acc_dot_reg[PW-1] || acc_dot_reg == '0)
                begin
                    dist_next  = acc_ap2_reg[LW-1:0];
                    state_next = ST_FOLD;
                end
                else if (acc_dot_reg >= acc_len2_reg)
                begin
                    dist_next  = acc_bp2_reg[LW-1:0];
                    state_next = ST_FOLD;
                end
                else
                begin
                    dsh_next   = acc_dot_reg[LW-1:0];
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = CW'(LW - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                priority if (k2)
                begin
                    rem_next = LW'(s_sum - len2_e);
                end
                else if (k1)
                begin
                    rem_next = LW'(s_sum - len_e);
                end
                else
                begin
                    rem_next = s_sum[LW-1:0];
                end
                quo_next = {quo_reg[LW-2:0], 1'b0} + LW'({k2, k1 & ~k2});
                dsh_next = dsh_reg << 1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SUB;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SUB:
            begin
                dist_next  = acc_ap2_reg[LW-1:0] - quo_reg;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (!last_reg)
                begin
                    run_min_next = min_new;
                    state_next   = ST_IDLE;
                end
                else if (out_free)
                begin
                    m_dist_next   = (min_new > {1'b0, psdm_pkg::OUT_DIST_MAX})
                                    ? psdm_pkg::OUT_DIST_MAX
                                    : min_new[psdm_pkg::OUT_DIST_W-1:0];
                    m_near_next   = (min_new <= {1'b0, thresh_reg});
                    m_tvalid_next = 1'b1;
                    run_min_next  = psdm_pkg::DIST_MAX;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            run_min_reg  <= psdm_pkg::DIST_MAX;
            thresh_reg   <= psdm_pkg::THRESH_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            run_min_reg  <= run_min_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_apx_reg    <= q_apx_next;
        q_apy_reg    <= q_apy_next;
        q_abx_reg    <= q_abx_next;
        q_aby_reg    <= q_aby_next;
        q_bpx_reg    <= q_bpx_next;
        q_bpy_reg    <= q_bpy_next;
        m_apx_reg    <= m_apx_next;
        m_apy_reg    <= m_apy_next;
        m_abx_reg    <= m_abx_next;
        m_aby_reg    <= m_aby_next;
        m_bpx_reg    <= m_bpx_next;
        m_bpy_reg    <= m_bpy_next;
        acc_ap2_reg  <= acc_ap2_next;
        acc_bp2_reg  <= acc_bp2_next;
        acc_dot_reg  <= acc_dot_next;
        acc_len2_reg <= acc_len2_next;
        dsh_reg      <= dsh_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dist_reg     <= dist_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        m_dist_reg   <= m_dist_next;
        m_near_reg   <= m_near_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(psdm_pkg::OUT_TDATA_W-psdm_pkg::OUT_DIST_W){1'b0}}, m_dist_reg};
    assign m_tuser  = m_near_reg;

endmodule

FILE: rtl/psdm_checker.sv
`timescale 1ns / 1ps

module psdm_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic s_tlast,
    input logic m_tvalid,
    input logic m_tready,
    input logic [psdm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic cfg_wr_en,
    input logic [psdm_pkg::OUT_DIST_W-1:0] cfg_wr_data
);

    // run ends accepted but not yet delivered
    logic [1:0] pend_reg;
    psdm_pkg::out_dist_t thr_reg;
    logic inc, dec;

    assign inc = s_tvalid && s_tready && s_tlast;
    assign dec = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            thr_reg  <= psdm_pkg::THRESH_RESET;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, inc} - {1'b0, dec};
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_out_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("output item without a finished run");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two runs outstanding");

    a_near_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[psdm_pkg::OUT_DIST_W-1:0] != psdm_pkg::OUT_DIST_MAX
        |-> m_tuser[0] == (m_tdata[psdm_pkg::OUT_DIST_W-1:0] <= thr_reg))
        else $error("near flag disagrees with threshold");

    a_reset_out: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind point_segment_distance_min psdm_checker u_psdm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
);

FILE: verif/psdm_min_checker.sv
`timescale 1ns / 1ps

module psdm_min_checker #(
    parameter int COORD_BITS = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  logic s_tready,
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input  logic [0:0] s_tuser,
    input  logic s_tlast,
    input  logic m_tvalid,
    input  logic m_tready,
    input  logic [psdm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [0:0] m_tuser,
    input  logic cfg_wr_en,
    input  logic [psdm_pkg::OUT_DIST_W-1:0] cfg_wr_data,
    output int fail_count,
    output int pending,
    output int results_checked
);
    import psdm_pkg::*;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        out_dist_t min_dist;
        logic      near;
    } run_result_t;

    run_result_t expected_mins[$];
    dist_t       running_min = DIST_MAX;
    out_dist_t   near_threshold = THRESH_RESET;
    int          fails = 0;
    int          checked = 0;
    int          waiting = 0;

    assign fail_count      = fails;
    assign pending         = waiting;
    assign results_checked = checked;

    // clamped projection, exact integer form
    function automatic dist_t segment_sq_distance(input coord_t px, input coord_t py,
                                                  input coord_t ax, input coord_t ay,
                                                  input coord_t bx, input coord_t by);
        longint apx, apy, abx, aby, bpx, bpy, dot, len2, d;
        apx  = longint'(px) - longint'(ax);
        apy  = longint'(py) - longint'(ay);
        abx  = longint'(bx) - longint'(ax);
        aby  = longint'(by) - longint'(ay);
        bpx  = longint'(px) - longint'(bx);
        bpy  = longint'(py) - longint'(by);
        dot  = apx * abx + apy * aby;
        len2 = abx * abx + aby * aby;
        if (len2 == 0 || dot <= 0)
            d = apx * apx + apy * apy;
        else if (dot >= len2)
            d = bpx * bpx + bpy * bpy;
        else
            d = apx * apx + apy * apy - (dot * dot) / len2;
        if (d > longint'(DIST_MAX))
            d = longint'(DIST_MAX);
        return dist_t'(d);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        dist_t       d;
        run_result_t want;
        if (!rst_n)
        begin
            running_min    = DIST_MAX;
            near_threshold = THRESH_RESET;
            expected_mins.delete();
            waiting        = 0;
        end
        else
        begin
            // retire before predicting: an item taken this edge cannot be answered this edge
            if (m_tvalid && m_tready)
            begin
                if (expected_mins.size() == 0)
                    report_mismatch($sformatf("unexpected result min_sq_distance %0d near %0d",
                                              m_tdata[OUT_DIST_W-1:0], m_tuser[0]));
                else
                begin
                    want = expected_mins.pop_front();
                    checked++;
                    if (m_tdata[OUT_DIST_W-1:0] !== want.min_dist)
                        report_mismatch($sformatf("min_sq_distance got %0d expected %0d",
                                                  m_tdata[OUT_DIST_W-1:0], want.min_dist));
                    if (m_tuser[0] !== want.near)
                        report_mismatch($sformatf("near got %0d expected %0d (min %0d)",
                                                  m_tuser[0], want.near, want.min_dist));
                end
            end
            if (s_tvalid && s_tready)
            begin
                d = segment_sq_distance(s_tdata[0*COORD_BITS +: COORD_BITS],
                                        s_tdata[1*COORD_BITS +: COORD_BITS],
                                        s_tdata[2*COORD_BITS +: COORD_BITS],
                                        s_tdata[3*COORD_BITS +: COORD_BITS],
                                        s_tdata[4*COORD_BITS +: COORD_BITS],
                                        s_tdata[5*COORD_BITS +: COORD_BITS]);
                if (s_tuser[0] || d < running_min)
                    running_min = d;
                if (s_tlast)
                begin
                    want.min_dist = (running_min > dist_t'(OUT_DIST_MAX)) ?
                                    OUT_DIST_MAX : running_min[OUT_DIST_W-1:0];
                    want.near     = (running_min <= dist_t'(near_threshold));
                    expected_mins.push_back(want);
                    running_min   = DIST_MAX;
                end
            end
            if (cfg_wr_en)
                near_threshold = cfg_wr_data;
            waiting = expected_mins.size();
        end
    end

endmodule

FILE: verif/tb_point_segment_distance_min.sv
`timescale 1ns / 1ps

module tb_point_segment_distance_min;
    import psdm_pkg::*;

    localparam int CB              = 10;
    localparam int S_TDATA_W       = ((6*CB+7)/8)*8;
    localparam int COORD_MAX       = (1 << CB) - 1;
    localparam int RESET_CYCLES    = 5;
    localparam int DRAIN_CYCLES    = 48;
    localparam int HOLD_CYCLES     = 500;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int PHASES          = 7;
    localparam int PRESSURE_ITEMS  = 24;
    localparam out_dist_t RANGE_MAX_DIST = 21'd2093058;

    typedef logic [CB-1:0] coord_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [OUT_DIST_W-1:0]  cfg_wr_data = '0;

    int fail_count;
    int pending;
    int results_checked;
    int items_sent = 0;
    int settings_written = 0;
    int quiet_cycles = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    point_segment_distance_min #(
        .COORD_BITS (CB)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    psdm_min_checker #(
        .COORD_BITS (CB)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // mostly short gaps, a few long ones
    function automatic int gap_cycles();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // endpoint close to the query point most of the time, anywhere otherwise
    function automatic coord_t pick_endpoint(input coord_t c);
        int v;
        if ($urandom_range(0, 9) < 4)
            return coord_t'($urandom_range(0, COORD_MAX));
        v = $urandom_range(0, 80);
        v = v - 40 + int'(c);
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    task automatic send_segment(input coord_t px, input coord_t py,
                                input coord_t ax, input coord_t ay,
                                input coord_t bx, input coord_t by,
                                input bit first, input bit last);
        int gap;
        s_tdata  = S_TDATA_W'({by, bx, ay, ax, py, px});
        s_tuser  = first;
        s_tlast  = last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
        gap = gap_cycles();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // one pixel against a chain of segments; scrambled runs get random flags
    task automatic send_random_run(input int len, input bit scramble);
        coord_t px, py, ax, ay, bx, by;
        bit     first, last;
        px = coord_t'($urandom_range(0, COORD_MAX));
        py = coord_t'($urandom_range(0, COORD_MAX));
        ax = pick_endpoint(px);
        ay = pick_endpoint(py);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                bx = ax;
                by = ay;
            end
            else
            begin
                bx = pick_endpoint(px);
                by = pick_endpoint(py);
            end
            first = scramble ? bit'($urandom_range(0, 1)) : (k == 0);
            last  = scramble ? bit'($urandom_range(0, 1)) : (k == len - 1);
            send_segment(px, py, ax, ay, bx, by, first, last);
            if ($urandom_range(0, 3) == 0)
            begin
                ax = pick_endpoint(px);
                ay = pick_endpoint(py);
            end
            else
            begin
                ax = bx;
                ay = by;
            end
        end
    endtask

    // idle input, wait out results and any item still in the datapath
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input out_dist_t value);
        cfg_wr_data = value;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        settings_written++;
    endtask

    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            n = gap_cycles();
            if (n > 0)
            begin
                m_tready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int        target;
        int        r;
        int        len;
        out_dist_t thr;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // threshold still at its reset value here
        send_segment(1023, 1023,    0,    0,    0,    0, 1'b0, 1'b1); // no first flag after reset
        send_segment(   0,    0,    0,    0,    0,    0, 1'b1, 1'b1);
        send_segment(   0,    0, 1023, 1023, 1023, 1023, 1'b1, 1'b1);
        send_segment(1023, 1023, 1023, 1023, 1023, 1023, 1'b1, 1'b1);
        send_segment(1023,    0,    0, 1023, 1023, 1023, 1'b1, 1'b1); // lands on end point
        send_segment(   0,    0,   10,   10,   20,   20, 1'b1, 1'b1); // behind start
        send_segment(  30,   30,   10,   10,   20,   20, 1'b1, 1'b1); // past end
        send_segment(  10,    5,    0,    0,   10,    0, 1'b1, 1'b1); // projection exactly on end
        send_segment(   0,    5,    0,    0,   10,    0, 1'b1, 1'b1); // projection exactly on start
        send_segment(   5,   15,    0,    0,   20,   20, 1'b1, 1'b1); // equals threshold
        send_segment(   5,   16,    0,    0,   20,   20, 1'b1, 1'b1); // division rounds down
        send_segment( 512,  700,    0, 1023, 1023,    0, 1'b1, 1'b1);
        // closed square around the point
        send_segment(  50,   50,   40,   40,   60,   40, 1'b1, 1'b0);
        send_segment(  50,   50,   60,   40,   60,   60, 1'b0, 1'b0);
        send_segment(  50,   50,   60,   60,   40,   60, 1'b0, 1'b0);
        send_segment(  50,   50,   40,   60,   40,   40, 1'b0, 1'b1);
        send_segment(   3,    4,    0,    0,    0,    0, 1'b0, 1'b1); // no first flag after a result
        // restart in the middle of a run drops the earlier minimum
        send_segment(   0,    0,    0,    0,    1,    0, 1'b1, 1'b0);
        send_segment( 100,  100,    0,    0,    0,    0, 1'b1, 1'b0);
        send_segment( 100,  100,   90,  100,   90,  100, 1'b0, 1'b1);
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       thr = '0;
                1:       thr = OUT_DIST_MAX;
                2:       thr = RANGE_MAX_DIST;
                3:       thr = out_dist_t'($urandom_range(0, 200));
                4:       thr = out_dist_t'($urandom_range(0, 2093058));
                5:       thr = THRESH_RESET;
                default: thr = out_dist_t'($urandom_range(0, 20000));
            endcase
            write_threshold(thr);
            no_gaps = (ph == 2);

            if (ph == 4)
            begin
                // output held off while single-segment runs keep coming
                no_gaps  = 1'b1;
                hold_req = 1'b1;
                while (hold_req)
                    @(negedge clk);
                for (int i = 0; i < PRESSURE_ITEMS; i++)
                    send_random_run(1, 1'b0);
                no_gaps = 1'b0;
            end

            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, 4);
                else if (r < 95)
                    len = $urandom_range(5, 12);
                else
                    len = $urandom_range(20, 40);
                send_random_run(len, $urandom_range(0, 9) == 0);
            end
            settle();
        end

        $display("covered %0d segment items, %0d run minimums checked", items_sent,
                 results_checked);
        $display("%0d threshold settings incl. 0 and all ones, one long output stall",
                 settings_written);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: point_segment_distance_min.f
rtl/psdm_pkg.sv
rtl/point_segment_distance_min.sv
rtl/psdm_checker.sv
verif/psdm_min_checker.sv
verif/tb_point_segment_distance_min.sv
